/* rtl/core/tsr_pkg.sv */
// Shared constants and controller/datapath interface types of the stream reassembler.
`default_nettype none
package tsr_pkg;

  // Reorder window depth in bytes; must be a power of two.
  localparam int unsigned WINDOW = 4096;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned DATA_W = 8;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned PCNT_W = 13;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned PEND_W = (CNT_W > PCNT_W) ? CNT_W : PCNT_W;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef struct packed {
    logic capture;
    logic clr_en;
    logic rd_en;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/tsr_ctrl.sv */
// Controller state machine of the stream reassembler.
`default_nettype none
module tsr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire tsr_pkg::status_t status_i,
  output tsr_pkg::cmd_t       cmd_o,
  output logic                busy_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (start_i) state_d = ST_READ;
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && start_i;
    cmd_o.clr_en  = (state_q == ST_CLEAR);
    cmd_o.rd_en   = (state_q == ST_READ);
    cmd_o.exec    = (state_q == ST_EXEC);
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
`default_nettype wire

/* rtl/core/tsr_datapath.sv */
// Datapath of the stream reassembler: window memories, head, pending count and result registers.
`default_nettype none
module tsr_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tsr_pkg::cmd_t                cmd_i,
  output tsr_pkg::status_t                  status_o,
  input  wire logic                         op_i,
  input  wire logic [tsr_pkg::DATA_W-1:0]   data_value_i,
  input  wire logic [tsr_pkg::POS_W-1:0]    stream_pos_i,
  input  wire logic                         carries_data_i,
  input  wire logic                         ends_stream_i,
  output logic                              result_valid_o,
  output logic                              accepted_o,
  output logic                              delivered_o,
  output logic [tsr_pkg::DATA_W-1:0]        out_value_o,
  output logic [tsr_pkg::POS_W-1:0]         next_expected_o,
  output logic [tsr_pkg::PCNT_W-1:0]        pending_count_o,
  output logic                              stream_done_o
);

  localparam logic [tsr_pkg::POS_W:0] WIN_EXT = (tsr_pkg::POS_W + 1)'(tsr_pkg::WINDOW);

  // Window memories: valid bits are cleared after reset, byte values are not.
  logic                        valid_mem [tsr_pkg::WINDOW];
  logic [tsr_pkg::DATA_W-1:0]  byte_mem  [tsr_pkg::WINDOW];

  // Captured item.
  logic                        op_q;
  logic [tsr_pkg::DATA_W-1:0]  data_q;
  logic [tsr_pkg::POS_W-1:0]   pos_q;
  logic                        carries_q;
  logic                        ends_q;

  logic                        valid_rd_q;
  logic [tsr_pkg::DATA_W-1:0]  byte_rd_q;

  logic [tsr_pkg::POS_W-1:0]   head_q, head_d;
  logic [tsr_pkg::PEND_W-1:0]  pend_q, pend_d;
  logic                        eof_q, eof_d;
  logic [tsr_pkg::SLOT_W-1:0]  clr_cnt_q;

  logic                        res_valid_q;
  logic                        accepted_q;
  logic                        delivered_q;
  logic [tsr_pkg::DATA_W-1:0]  out_value_q;
  logic [tsr_pkg::POS_W-1:0]   next_exp_q;
  logic [tsr_pkg::PCNT_W-1:0]  pcount_q;
  logic                        done_q;

  logic [tsr_pkg::SLOT_W-1:0]  slot;
  logic                        in_win;
  logic                        not_behind;
  logic                        store;
  logic                        latch_eof;
  logic                        deliver;
  logic                        vwe;
  logic [tsr_pkg::SLOT_W-1:0]  vaddr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      data_q    <= data_value_i;
      pos_q     <= stream_pos_i;
      carries_q <= carries_data_i;
      ends_q    <= ends_stream_i;
    end
  end

  // The window depth is a power of two, so the ring slot is the low bits of the position.
  assign slot = (op_q == tsr_pkg::OP_PULL) ? head_q[tsr_pkg::SLOT_W-1:0]
                                           : pos_q[tsr_pkg::SLOT_W-1:0];

  assign in_win     = {1'b0, pos_q} < ({1'b0, head_q} + WIN_EXT);
  assign not_behind = pos_q >= head_q;
  assign store      = (op_q == tsr_pkg::OP_PUSH) && in_win && not_behind && carries_q
                      && !valid_rd_q;
  assign latch_eof  = (op_q == tsr_pkg::OP_PUSH) && in_win && ends_q;
  assign deliver    = (op_q == tsr_pkg::OP_PULL) && valid_rd_q;

  always_comb begin
    head_d = head_q;
    pend_d = pend_q;
    eof_d  = eof_q || latch_eof;
    if (store) begin
      pend_d = pend_q + tsr_pkg::PEND_W'(1);
    end
    if (deliver) begin
      head_d = head_q + tsr_pkg::POS_W'(1);
      if (pend_q != '0) begin
        pend_d = pend_q - tsr_pkg::PEND_W'(1);
      end
    end
  end

  assign vwe   = cmd_i.clr_en || (cmd_i.exec && (store || deliver));
  assign vaddr = cmd_i.clr_en ? clr_cnt_q : slot;

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      valid_mem[vaddr] <= !cmd_i.clr_en && store;
    end
    if (cmd_i.rd_en) begin
      valid_rd_q <= valid_mem[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && store) begin
      byte_mem[slot] <= data_q;
    end
    if (cmd_i.rd_en) begin
      byte_rd_q <= byte_mem[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      pend_q      <= '0;
      eof_q       <= 1'b0;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.exec;
      if (cmd_i.clr_en) begin
        clr_cnt_q <= clr_cnt_q + tsr_pkg::SLOT_W'(1);
      end
      if (cmd_i.exec) begin
        head_q <= head_d;
        pend_q <= pend_d;
        eof_q  <= eof_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      accepted_q  <= store;
      delivered_q <= deliver;
      out_value_q <= deliver ? byte_rd_q : '0;
      next_exp_q  <= head_d;
      pcount_q    <= pend_d[tsr_pkg::PCNT_W-1:0];
      done_q      <= eof_d && (pend_d == '0);
    end
  end

  assign status_o.clr_last = (clr_cnt_q == tsr_pkg::SLOT_W'(tsr_pkg::WINDOW - 1));

  assign result_valid_o  = res_valid_q;
  assign accepted_o      = accepted_q;
  assign delivered_o     = delivered_q;
  assign out_value_o     = out_value_q;
  assign next_expected_o = next_exp_q;
  assign pending_count_o = pcount_q;
  assign stream_done_o   = done_q;

endmodule
`default_nettype wire

/* rtl/core/tcp_stream_reassembler.sv */
// The result strobe follows an accepted item after its read and execute states.
// Items are worked one at a time: capture, window slot read, update and write back;
// busy is low again while the result is shown, so the next item may enter then.
// Reset: head, pending count and end-of-stream flag clear at once; then the valid-bit
// memory is cleared in a pass over all 4096 slots (one slot per cycle) with busy high.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none
module tcp_stream_reassembler (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         op_i,
  input  wire logic [tsr_pkg::DATA_W-1:0]   data_value_i,
  input  wire logic [tsr_pkg::POS_W-1:0]    stream_pos_i,
  input  wire logic                         carries_data_i,
  input  wire logic                         ends_stream_i,
  output logic                              result_valid_o,
  output logic                              accepted_o,
  output logic                              delivered_o,
  output logic [tsr_pkg::DATA_W-1:0]        out_value_o,
  output logic [tsr_pkg::POS_W-1:0]         next_expected_o,
  output logic [tsr_pkg::PCNT_W-1:0]        pending_count_o,
  output logic                              stream_done_o
);

  tsr_pkg::cmd_t    cmd;
  tsr_pkg::status_t status;

  tsr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  tsr_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (op_i),
    .data_value_i    (data_value_i),
    .stream_pos_i    (stream_pos_i),
    .carries_data_i  (carries_data_i),
    .ends_stream_i   (ends_stream_i),
    .result_valid_o  (result_valid_o),
    .accepted_o      (accepted_o),
    .delivered_o     (delivered_o),
    .out_value_o     (out_value_o),
    .next_expected_o (next_expected_o),
    .pending_count_o (pending_count_o),
    .stream_done_o   (stream_done_o)
  );

endmodule
`default_nettype wire

/* rtl/core/tsr_checker.sv */
// Port-level assertions for the stream reassembler and their bind to the top level.
`default_nettype none
module tsr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic                         result_valid_o,
  input wire logic                         accepted_o,
  input wire logic                         delivered_o,
  input wire logic [tsr_pkg::DATA_W-1:0]   out_value_o
);

  // An accepted item keeps the block busy until its work is done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("block not busy after an accepted item");

  // Every accepted item gives its result after its read and execute states.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 result_valid_o)
    else $error("result missing three cycles after an accepted item");

  // Items are worked one at a time, so results never come in adjacent cycles.
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results in adjacent cycles");

  // A pull never stores a byte.
  a_deliver_not_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && delivered_o |-> !accepted_o)
    else $error("one item both stored and released a byte");

  // The released byte reads as zero when nothing was released.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !delivered_o |-> out_value_o == '0)
    else $error("byte value shown without a released byte");

endmodule

bind tcp_stream_reassembler tsr_checker u_tsr_checker (.*);
`default_nettype wire
